/* hw/rtl/rdeg_pkg.sv */
// Shared constants and handshake types for the random distinct edge generator.
package rdeg_pkg;

  // 64-bit Mersenne Twister geometry and constants
  localparam int          TW_N        = 312;
  localparam int          TW_M        = 156;
  localparam int          TW_AW       = $clog2(TW_N);
  localparam logic [63:0] TW_MATRIX   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TW_UPPER    = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TW_LOWER    = 64'h000000007FFFFFFF;
  localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;

  // Configuration register map
  localparam int         CFG_IDX_W        = 8;
  localparam logic [7:0] REG_VERTEX_COUNT = 8'd0;
  localparam logic [7:0] REG_SEED         = 8'd1;

  // Requests from the controller to the generator
  typedef struct packed {
    logic seed_go;
    logic next_go;
  } tw_req_t;

  // Completion pulses back from the generator
  typedef struct packed {
    logic seed_done;
    logic word_valid;
  } tw_rsp_t;

endpackage

/* hw/rtl/rdeg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module rdeg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rdeg_mod.sv */
// Bit-serial remainder unit: 64-bit dividend modulo a vertex-wide divisor.
module rdeg_mod #(
  parameter int VERTEX_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [63:0]            dividend,
  input  logic [VERTEX_BITS-1:0] divisor,
  output logic                   done,
  output logic [VERTEX_BITS-1:0] remainder
);

  logic [63:0]            dvd_r;
  logic [VERTEX_BITS-1:0] div_r;
  logic [VERTEX_BITS-1:0] rem_r;
  logic [6:0]             cnt_r;
  logic                   done_r;
  logic [VERTEX_BITS:0]   trial;
  logic [VERTEX_BITS:0]   trial_sub;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, dvd_r[63]};
    trial_sub = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        dvd_r <= dividend;
        div_r <= divisor;
        rem_r <= '0;
        cnt_r <= 7'd64;
      end else if (cnt_r != 7'd0) begin
        dvd_r <= {dvd_r[62:0], 1'b0};
        if (trial >= {1'b0, div_r}) begin
          rem_r <= trial_sub[VERTEX_BITS-1:0];
        end else begin
          rem_r <= trial[VERTEX_BITS-1:0];
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* hw/rtl/rdeg_twister.sv */
// Mersenne Twister 64 engine: seeding, block refill and tempered word output over one RAM.
module rdeg_twister (
  input  logic             clk,
  input  logic             rst_n,
  input  rdeg_pkg::tw_req_t req,
  input  logic [63:0]      seed,
  output rdeg_pkg::tw_rsp_t rsp,
  output logic [63:0]      word
);

  localparam int AW = rdeg_pkg::TW_AW;
  localparam logic [AW-1:0] LAST  = AW'(rdeg_pkg::TW_N - 1);
  localparam logic [AW-1:0] WRAP  = AW'(rdeg_pkg::TW_N - rdeg_pkg::TW_M);
  localparam logic [AW-1:0] MID   = AW'(rdeg_pkg::TW_M);
  localparam logic [AW-1:0] FULL  = AW'(rdeg_pkg::TW_N);

  typedef enum logic [3:0] {
    S_IDLE, S_SD0, S_P0, S_P1, S_P2, S_SWR,
    S_TST, S_TLD, S_TA, S_TB, S_TC, S_NRD, S_NDT
  } state_t;

  state_t         state_r;
  logic [AW-1:0]  idx_r;
  logic [AW-1:0]  pos_r;
  logic [63:0]    p_r;
  logic [63:0]    acc_r;
  logic [63:0]    mul_r;
  logic [63:0]    cur_r;
  logic [63:0]    nxt_r;
  logic [63:0]    word_r;
  logic           seed_done_r;
  logic           word_valid_r;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [63:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [63:0]    ram_rdata;

  logic [63:0]    x;
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    prod;
  logic [63:0]    seed_val;
  logic [AW-1:0]  idx_p1;
  logic [AW-1:0]  idx_pm;
  logic [63:0]    y;
  logic [63:0]    twist_val;
  logic [63:0]    t0, t1, t2, t3;

  rdeg_ram #(.WIDTH(64), .DEPTH(rdeg_pkg::TW_N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // seeding recurrence: low 64 bits of INIT_MUL * x from three 32x32 partial products
  always_comb begin
    x = p_r ^ (p_r >> 62);
    unique case (state_r)
      S_P0:    begin mul_a = x[31:0];  mul_b = rdeg_pkg::TW_INIT_MUL[31:0];  end
      S_P1:    begin mul_a = x[63:32]; mul_b = rdeg_pkg::TW_INIT_MUL[31:0];  end
      default: begin mul_a = x[31:0];  mul_b = rdeg_pkg::TW_INIT_MUL[63:32]; end
    endcase
    prod     = 64'(mul_a) * 64'(mul_b);
    seed_val = acc_r + {mul_r[31:0], 32'b0} + 64'(idx_r);
  end

  // refill neighbor addresses and new word
  always_comb begin
    idx_p1    = (idx_r == LAST) ? '0 : idx_r + AW'(1);
    idx_pm    = (idx_r >= WRAP) ? idx_r - WRAP : idx_r + MID;
    y         = (cur_r & rdeg_pkg::TW_UPPER) | (nxt_r & rdeg_pkg::TW_LOWER);
    twist_val = ram_rdata ^ (y >> 1) ^ (y[0] ? rdeg_pkg::TW_MATRIX : 64'd0);
  end

  // tempering of the word read at the current position
  always_comb begin
    t0 = ram_rdata ^ ((ram_rdata >> 29) & 64'h5555555555555555);
    t1 = t0 ^ ((t0 << 17) & 64'h71D67FFFEDA60000);
    t2 = t1 ^ ((t1 << 37) & 64'hFFF7EEE000000000);
    t3 = t2 ^ (t2 >> 43);
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = twist_val;
    ram_raddr = idx_r;
    unique case (state_r)
      S_SD0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed;
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ram_wdata = seed_val;
      end
      S_TST:   ram_raddr = '0;
      S_TA:    ram_raddr = idx_p1;
      S_TB:    ram_raddr = idx_pm;
      S_TC:    ram_we    = 1'b1;
      S_NRD:   ram_raddr = pos_r;
      default: ram_raddr = idx_r;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= FULL;
      idx_r        <= '0;
      seed_done_r  <= 1'b0;
      word_valid_r <= 1'b0;
    end else begin
      seed_done_r  <= 1'b0;
      word_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req.seed_go) begin
            state_r <= S_SD0;
          end else if (req.next_go) begin
            state_r <= (pos_r >= FULL) ? S_TST : S_NRD;
          end
        end
        S_SD0: begin
          p_r     <= seed;
          idx_r   <= AW'(1);
          state_r <= S_P0;
        end
        S_P0: begin
          mul_r   <= prod;
          state_r <= S_P1;
        end
        S_P1: begin
          acc_r   <= mul_r;
          mul_r   <= prod;
          state_r <= S_P2;
        end
        S_P2: begin
          acc_r   <= acc_r + {mul_r[31:0], 32'b0};
          mul_r   <= prod;
          state_r <= S_SWR;
        end
        S_SWR: begin
          p_r <= seed_val;
          if (idx_r == LAST) begin
            pos_r       <= FULL;
            seed_done_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_P0;
          end
        end
        S_TST: begin
          idx_r   <= '0;
          state_r <= S_TLD;
        end
        S_TLD: begin
          cur_r   <= ram_rdata;
          state_r <= S_TA;
        end
        S_TA: state_r <= S_TB;
        S_TB: begin
          nxt_r   <= ram_rdata;
          state_r <= S_TC;
        end
        S_TC: begin
          cur_r <= nxt_r;
          if (idx_r == LAST) begin
            pos_r   <= '0;
            state_r <= S_NRD;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_TA;
          end
        end
        S_NRD: state_r <= S_NDT;
        S_NDT: begin
          word_r       <= t3;
          word_valid_r <= 1'b1;
          pos_r        <= pos_r + AW'(1);
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.seed_done  = seed_done_r;
  assign rsp.word_valid = word_valid_r;
  assign word           = word_r;

endmodule

/* hw/rtl/random_distinct_edge_generator.sv */
// Top level: configuration registers, edge controller and result register.
//
// Each request produces one edge (source, target) of distinct vertex labels in 1..n (n below
// two counts as two) drawn from a 64-bit Mersenne Twister whose 312-word state lives in a
// single RAM. An edge takes two bit-serial remainders (one per endpoint) plus a generator
// word fetch per draw. Every 312 words the generator refills its block with three RAM
// accesses per word. A draw below the rejection threshold repeats that endpoint. The first
// request after reset or after a write of vertex_count computes the two thresholds first,
// and a reseed (restart, or the first request after reset) first runs the seeding multiply
// through S_P0, S_P1, S_P2 and S_SWR for each word. One request is worked on at a time; a
// finished edge waits in the output register while the next request is accepted.
module random_distinct_edge_generator #(
  parameter int VERTEX_BITS = 31
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [VERTEX_BITS-1:0]           out_source_vertex,
  output logic [VERTEX_BITS-1:0]           out_target_vertex,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rdeg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_data
);

  localparam int VB = VERTEX_BITS;

  typedef enum logic [3:0] {
    T_IDLE, T_SEED, T_CHK, T_DAW, T_DBW, T_DRAW, T_WAITW, T_MODW, T_OUT
  } state_t;

  state_t            state_r;
  logic [VB-1:0]     vc_r;
  logic [63:0]       seed_r;
  logic              seeded_r;
  logic              disc_ok_r;
  logic [VB-1:0]     disc_a_r;
  logic [VB-1:0]     disc_b_r;
  logic              sel_v_r;
  logic [VB-1:0]     u_r;
  logic [VB-1:0]     v_r;
  logic              out_valid_r;
  logic [VB-1:0]     out_src_r;
  logic [VB-1:0]     out_tgt_r;
  rdeg_pkg::tw_req_t tw_req_r;
  logic              mod_go_r;
  logic [63:0]       mod_dvd_r;
  logic [VB-1:0]     mod_div_r;

  rdeg_pkg::tw_rsp_t tw_rsp;
  logic [63:0]       tw_word;
  logic              mod_done;
  logic [VB-1:0]     mod_rem;

  logic [VB-1:0]     lim_a;
  logic [VB-1:0]     lim_b;
  logic [VB-1:0]     lim_sel;
  logic [VB-1:0]     disc_sel;
  logic [VB-1:0]     v_adj;
  logic              in_acc;

  rdeg_twister u_twister (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tw_req_r),
    .seed  (seed_r),
    .rsp   (tw_rsp),
    .word  (tw_word)
  );

  rdeg_mod #(.VERTEX_BITS(VB)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (mod_go_r),
    .dividend  (mod_dvd_r),
    .divisor   (mod_div_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // limits: n saturated to two, and n-1 for the target draw
  always_comb begin
    lim_a    = (vc_r < VB'(2)) ? VB'(2) : vc_r;
    lim_b    = lim_a - VB'(1);
    lim_sel  = sel_v_r ? lim_b : lim_a;
    disc_sel = sel_v_r ? disc_b_r : disc_a_r;
    v_adj    = (v_r >= u_r) ? v_r + VB'(1) : v_r;
  end

  assign in_ready  = (state_r == T_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r   <= VB'(2);
      seed_r <= 64'd1;
    end else if (cfg_valid) begin
      if (cfg_index == rdeg_pkg::REG_VERTEX_COUNT) begin
        vc_r <= cfg_data[VB-1:0];
      end else if (cfg_index == rdeg_pkg::REG_SEED) begin
        seed_r <= cfg_data;
      end
    end
  end

  // edge controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      seeded_r    <= 1'b0;
      disc_ok_r   <= 1'b0;
      sel_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      tw_req_r    <= '0;
      mod_go_r    <= 1'b0;
    end else begin
      tw_req_r <= '0;
      mod_go_r <= 1'b0;
      // result taken; T_OUT reloads the register itself
      if (out_ready && state_r != T_OUT) begin
        out_valid_r <= 1'b0;
      end
      // a new vertex count invalidates the cached thresholds
      if (cfg_valid && cfg_index == rdeg_pkg::REG_VERTEX_COUNT) begin
        disc_ok_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            seeded_r <= 1'b1;
            sel_v_r  <= 1'b0;
            if (in_restart || !seeded_r) begin
              tw_req_r.seed_go <= 1'b1;
              state_r          <= T_SEED;
            end else begin
              state_r <= T_CHK;
            end
          end
        end
        T_SEED: begin
          if (tw_rsp.seed_done) begin
            state_r <= T_CHK;
          end
        end
        T_CHK: begin
          if (disc_ok_r) begin
            state_r <= T_DRAW;
          end else begin
            mod_go_r  <= 1'b1;
            mod_dvd_r <= 64'd0 - 64'(lim_a);
            mod_div_r <= lim_a;
            state_r   <= T_DAW;
          end
        end
        T_DAW: begin
          if (mod_done) begin
            disc_a_r  <= mod_rem;
            mod_go_r  <= 1'b1;
            mod_dvd_r <= 64'd0 - 64'(lim_b);
            mod_div_r <= lim_b;
            state_r   <= T_DBW;
          end
        end
        T_DBW: begin
          if (mod_done) begin
            disc_b_r  <= mod_rem;
            disc_ok_r <= 1'b1;
            state_r   <= T_DRAW;
          end
        end
        T_DRAW: begin
          tw_req_r.next_go <= 1'b1;
          state_r          <= T_WAITW;
        end
        T_WAITW: begin
          if (tw_rsp.word_valid) begin
            // draws below the threshold are rejected and redrawn
            if (tw_word >= 64'(disc_sel)) begin
              mod_go_r  <= 1'b1;
              mod_dvd_r <= tw_word;
              mod_div_r <= lim_sel;
              state_r   <= T_MODW;
            end else begin
              state_r <= T_DRAW;
            end
          end
        end
        T_MODW: begin
          if (mod_done) begin
            if (!sel_v_r) begin
              u_r     <= mod_rem;
              sel_v_r <= 1'b1;
              state_r <= T_DRAW;
            end else begin
              v_r     <= mod_rem;
              state_r <= T_OUT;
            end
          end
        end
        T_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_src_r   <= u_r + VB'(1);
            out_tgt_r   <= v_adj + VB'(1);
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_source_vertex = out_src_r;
  assign out_target_vertex = out_tgt_r;

endmodule

/* hw/rtl/rdeg_checker.sv */
// Port-level checker for the random distinct edge generator, bound to the top level.
module rdeg_checker #(
  parameter int VERTEX_BITS = 31
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [VERTEX_BITS-1:0]         out_source_vertex,
  input logic [VERTEX_BITS-1:0]         out_target_vertex
);

  // a stalled edge holds its endpoints
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_vertex)
      && $stable(out_target_vertex))
    else $error("stalled result changed");

  // endpoints are always distinct
  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_source_vertex != out_target_vertex)
    else $error("edge endpoints equal");

  // labels start at one
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_source_vertex != '0 && out_target_vertex != '0)
    else $error("zero vertex label");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind random_distinct_edge_generator rdeg_checker #(.VERTEX_BITS(VERTEX_BITS)) u_rdeg_checker (.*);

/* bench/testbench.sv */
// Self-checking testbench for the random distinct edge generator.
module testbench;

  localparam int          VB         = 31;
  localparam int          CYCLE_CAP  = 2_000_000;
  localparam int          BLOCKS     = 8;
  localparam int          BLOCK_LEN  = 54;
  localparam logic [63:0] COUNT_MASK = (64'd1 << VB) - 1;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_restart = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VB-1:0] out_source_vertex;
  logic [VB-1:0] out_target_vertex;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [7:0]    cfg_index = '0;
  logic [63:0]   cfg_data = '0;

  random_distinct_edge_generator #(.VERTEX_BITS(VB)) dut (.*);

  always #1 clk = ~clk;

  // Mirror of the twister and the registers
  logic [63:0] tw_words[rdeg_pkg::TW_N];
  int          tw_pos;
  bit          tw_seeded;
  logic [63:0] reg_count;
  logic [63:0] reg_seed;

  typedef struct {
    logic [VB-1:0] src;
    logic [VB-1:0] dst;
  } edge_t;
  edge_t pending_edges[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int cycles = 0;
  int mismatches = 0;
  int edges_sent = 0;
  int edges_seen = 0;
  int restarts = 0;
  int cfg_writes = 0;

  function automatic void tw_reseed(logic [63:0] s);
    tw_words[0] = s;
    for (int i = 1; i < rdeg_pkg::TW_N; i++)
      tw_words[i] = rdeg_pkg::TW_INIT_MUL * (tw_words[i-1] ^ (tw_words[i-1] >> 62))
                    + 64'(i);
    tw_pos = rdeg_pkg::TW_N;
  endfunction

  function automatic void tw_refill();
    logic [63:0] y;
    logic [63:0] v;
    for (int i = 0; i < rdeg_pkg::TW_N; i++) begin
      y = (tw_words[i] & rdeg_pkg::TW_UPPER) |
          (tw_words[(i + 1) % rdeg_pkg::TW_N] & rdeg_pkg::TW_LOWER);
      v = tw_words[(i + rdeg_pkg::TW_M) % rdeg_pkg::TW_N] ^ (y >> 1);
      if (y[0]) v = v ^ rdeg_pkg::TW_MATRIX;
      tw_words[i] = v;
    end
    tw_pos = 0;
  endfunction

  function automatic logic [63:0] tw_next();
    logic [63:0] z;
    if (tw_pos >= rdeg_pkg::TW_N) tw_refill();
    z = tw_words[tw_pos];
    tw_pos++;
    z = z ^ ((z >> 29) & 64'h5555555555555555);
    z = z ^ ((z << 17) & 64'h71D67FFFEDA60000);
    z = z ^ ((z << 37) & 64'hFFF7EEE000000000);
    z = z ^ (z >> 43);
    return z;
  endfunction

  // Uniform draw in 0..limit-1, rejecting the biased low band
  function automatic logic [63:0] draw_uniform(logic [63:0] limit);
    logic [63:0] cut;
    logic [63:0] x;
    cut = (64'd0 - limit) % limit;
    do x = tw_next(); while (x < cut);
    return x % limit;
  endfunction

  function automatic edge_t predict_edge(bit restart);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] v;
    edge_t e;
    if (restart || !tw_seeded) begin
      tw_reseed(reg_seed);
      tw_seeded = 1'b1;
    end
    n = (reg_count < 2) ? 64'd2 : reg_count;
    u = draw_uniform(n);
    v = draw_uniform(n - 1);
    if (v >= u) v++;
    e.src = VB'(u + 1);
    e.dst = VB'(v + 1);
    return e;
  endfunction

  // Monitor: config writes, accepted requests and returned edges
  always @(posedge clk) begin
    edge_t e;
    cycles <= cycles + 1;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == rdeg_pkg::REG_VERTEX_COUNT) reg_count = cfg_data & COUNT_MASK;
      else if (cfg_index == rdeg_pkg::REG_SEED) reg_seed = cfg_data;
    end
    if (rst_n && in_valid && in_ready)
      pending_edges.push_back(predict_edge(in_restart));
    if (rst_n && out_valid && out_ready) begin
      edges_seen++;
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected edge (%0d,%0d)", out_source_vertex, out_target_vertex);
      end else begin
        e = pending_edges.pop_front();
        if (e.src !== out_source_vertex || e.dst !== out_target_vertex) begin
          mismatches++;
          if (mismatches <= 10)
            $display("edge %0d: expected (%0d,%0d) got (%0d,%0d)", edges_seen,
                     e.src, e.dst, out_source_vertex, out_target_vertex);
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end

  // Receiver back-pressure
  always @(negedge clk)
    if (rst_n) out_ready <= ($urandom_range(99) >= out_stall_pct);

  task automatic send_edge(bit restart);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_restart = restart;
    do @(posedge clk); while (!in_ready);
    edges_sent++;
    restarts += restart;
  endtask

  // Drop valid and wait until every edge is back, then settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  // Directed rows: either a register write or one request
  typedef struct {
    bit          is_cfg;
    logic [7:0]  idx;
    logic [63:0] data;
    bit          restart;
  } row_t;

  row_t plan[] = '{
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},                 // first request seeds anyway
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, rdeg_pkg::REG_SEED, 64'd0, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},                 // new seed not yet in use
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 1},
    '{1, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},                 // saturates to two
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, rdeg_pkg::REG_VERTEX_COUNT, 64'd1, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, rdeg_pkg::REG_VERTEX_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 0}, // high bits masked off
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 1},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, 8'd2, 64'd5, 0},                                       // unmapped indexes ignored
    '{1, 8'hFF, 64'd7, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, rdeg_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 1},
    '{1, rdeg_pkg::REG_VERTEX_COUNT, 64'd3, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0},
    '{1, rdeg_pkg::REG_VERTEX_COUNT, 64'h7FFF_FFFE, 0},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 1},
    '{0, rdeg_pkg::REG_VERTEX_COUNT, 64'd0, 0}
  };

  int idle_mix[4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{28, 28}};

  initial begin
    logic [63:0] n;
    reg_count = 64'd2;
    reg_seed = 64'd1;
    tw_seeded = 1'b0;
    tw_pos = rdeg_pkg::TW_N;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else send_edge(plan[i].restart);
    end

    // Random phases, each a run of blocks under a fresh configuration
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = idle_mix[ph][0];
      out_stall_pct = idle_mix[ph][1];
      for (int b = 0; b < BLOCKS; b++) begin
        drain();
        case ($urandom_range(7))
          0: n = {$urandom, $urandom};                // garbage above the field
          1: n = 64'($urandom_range(1, 0));
          2: n = 64'h7FFF_FFFF;
          3: n = 64'($urandom_range(2, 16));
          4: n = 64'($urandom_range(2, 1000));
          default: n = {33'd0, 31'($urandom)};
        endcase
        write_reg(rdeg_pkg::REG_VERTEX_COUNT, n);
        if ($urandom_range(3) != 0)
          write_reg(rdeg_pkg::REG_SEED, ($urandom_range(7) == 0) ? {64{1'($urandom)}}
                                                                 : {$urandom, $urandom});
        if ($urandom_range(7) == 0) write_reg(8'($urandom_range(255, 2)), {$urandom, $urandom});
        for (int k = 0; k < BLOCK_LEN; k++)
          send_edge(($urandom_range(15) == 0) || (k == 0 && $urandom_range(1) == 0));
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (pending_edges.size() != 0) mismatches++;
    $display("%0d edges (%0d with restart), %0d register writes, %0d cycles",
             edges_sent, restarts, cfg_writes, cycles);
    $display("%0d edges checked, %0d mismatches", edges_seen, mismatches);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
